>>> hw/rtl/scwrl_pkg.sv
// Shared constants, codes and types for the shared-credit write rate limiter.
package scwrl_pkg;

	localparam int MAX_CLIENTS_DEF = 64;

	localparam int CMD_W    = 2;
	localparam int CLIENT_W = 6;
	localparam int NOW_W    = 48;
	localparam int TMO_W    = 32;
	localparam int OCRED_W  = 31;
	localparam int CFG_W    = 30;
	localparam int CFGI_W   = 3;
	localparam int LIVE_W   = 7;
	localparam int CRED_W   = 34;
	localparam int MEMC_W   = 32;
	localparam int EL_W     = 30;
	localparam int COST_W   = 20;

	localparam int DIV_N_W  = 60;
	localparam int DIV_D_W  = 30;
	localparam int DIV_C_W  = 6;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 96;

	localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHARGE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	localparam logic [CFGI_W-1:0] CFG_WRITE_COST   = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_REFILL_RATE  = 3'd1;
	localparam logic [CFGI_W-1:0] CFG_CLIENT_BURST = 3'd2;
	localparam logic [CFGI_W-1:0] CFG_GLOBAL_BURST = 3'd3;
	localparam logic [CFGI_W-1:0] CFG_FLOOR        = 3'd4;
	localparam logic [CFGI_W-1:0] CFG_CEILING      = 3'd5;

	localparam logic [LIVE_W-1:0] LIVE_CAP    = 7'd127;
	localparam logic [EL_W-1:0]   ELAPSED_CAP = 30'd1000000000;
	localparam logic [9:0]        MS_PER_S    = 10'd1000;
	localparam logic [TMO_W-1:0]  WAKE_CAP    = 32'h7FFF_FFFF;

	typedef logic signed [CRED_W-1:0] cred_t;

	localparam cred_t CREDIT_LOW = -34'sd1073741824;

endpackage

>>> hw/rtl/scwrl_div.sv
// Shared restoring divider, one quotient bit per cycle.
module scwrl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [scwrl_pkg::DIV_N_W-1:0]   dividend,
	input  logic [scwrl_pkg::DIV_D_W-1:0]   divisor,
	output logic                            done,
	output logic [scwrl_pkg::DIV_N_W-1:0]   quotient
);
	import scwrl_pkg::*;

	logic               busy_q;
	logic [DIV_C_W-1:0] cnt_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W:0]   diff;
	logic               take;

	assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign take   = rem_sh >= {1'b0, dvs_q};
	assign done   = busy_q && (cnt_q == DIV_C_W'(1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_C_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_C_W'(1);
			if (cnt_q == DIV_C_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], take};
		end
	end

endmodule

>>> hw/rtl/shared_credit_write_rate_limiter_unit.sv
// Top level: per-client credit limiter with shared reserve, sequenced over one divider.
// Open and close pass load, open or close, then output. Charge and query may run a
// refill division, query a timeout one; each division runs 60 steps on the divider.
// One transaction at a time: s_tready is high only while the sequencer is idle.
// Accept resumes once the result leaves ST_OUT, which any wait on m_tready delays.
// arst_n clears config to defaults, valid flags (stored credits read as zero), reserve and live count.
module shared_credit_write_rate_limiter_unit #(
	parameter int MAX_CLIENTS = scwrl_pkg::MAX_CLIENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scwrl_pkg::CFGI_W-1:0]      cfg_idx,
	input  logic [scwrl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scwrl_pkg::CMD_W-1:0]       s_tuser,  // cmd
	input  logic [scwrl_pkg::IN_DATA_W-1:0]   s_tdata,  // client, now_ms, prev_timeout, pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// credit_now, reserve_now, blocked, timeout, newly_affected
	output logic [scwrl_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import scwrl_pkg::*;

	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_LOAD  = 16'h0002,
		ST_OPEN  = 16'h0004,
		ST_CLOSE = 16'h0008,
		ST_MUL   = 16'h0010,
		ST_DSET  = 16'h0020,
		ST_DIV   = 16'h0040,
		ST_ADD   = 16'h0080,
		ST_MV1   = 16'h0100,
		ST_MV2   = 16'h0200,
		ST_MV3   = 16'h0400,
		ST_CHG   = 16'h0800,
		ST_TQ    = 16'h1000,
		ST_TM2   = 16'h2000,
		ST_TFIN  = 16'h4000,
		ST_OUT   = 16'h8000
	} state_t;

	function automatic cred_t mv_amt(input cred_t a, input cred_t b);
		cred_t x;
		x = (a < b) ? a : b;
		return (x > 0) ? x : '0;
	endfunction

	// config
	logic [COST_W-1:0] cost_q;
	logic [CFG_W-1:0]  rate_q, burst_q, gburst_q, floor_q, ceil_q;

	// item and working registers
	state_t                    st_q;
	logic [CMD_W-1:0]          cmd_q;
	logic [CLIENT_W-1:0]       cli_q;
	logic [NOW_W-1:0]          now_q;
	logic signed [TMO_W-1:0]   prev_q;
	logic signed [TMO_W-1:0]   tmo_q;
	logic                      newly_q;
	logic                      tq_q;
	cred_t                     c_q, r_q, sur_q;
	logic [LIVE_W-1:0]         live_q;
	logic [EL_W-1:0]           el_q;
	logic [DIV_N_W-1:0]        prod_q;
	logic [DIV_D_W-1:0]        dvs_q;

	// stores
	logic [MEMC_W-1:0] cred_mem [MAX_CLIENTS];
	logic [NOW_W-1:0]  stamp_mem [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] vld_q;
	logic [MAX_CLIENTS-1:0] aff_q;
	logic [MEMC_W-1:0] cred_rd_q;
	logic [NOW_W-1:0]  stamp_rd_q;

	logic               accept, out_free, leave_out, in_range;
	logic [IDX_W-1:0]   s_idx, idx;
	logic               div_start, div_done;
	logic [DIV_N_W-1:0] div_q;
	logic [NOW_W:0]     el_diff;
	logic [EL_W-1:0]    el_n;
	cred_t              ld_c, x1, x2, x3, cadd, qs, cchg, negc;
	logic [DIV_N_W-1:0] qsel;
	logic [TMO_W-1:0]   w;

	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign leave_out = (st_q == ST_OUT) && out_free;
	assign s_idx     = IDX_W'(s_tdata[CLIENT_W-1:0]);
	assign idx       = IDX_W'(cli_q);
	assign in_range  = int'(cli_q) < MAX_CLIENTS;
	assign div_start = (st_q == ST_DSET);

	scwrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// elapsed time, clamped to [0, 1e9]
	always_comb begin
		el_diff = {1'b0, now_q} - {1'b0, stamp_rd_q};
		if (el_diff[NOW_W])
			el_n = '0;
		else if (el_diff[NOW_W-1:0] > NOW_W'(ELAPSED_CAP))
			el_n = ELAPSED_CAP;
		else
			el_n = el_diff[EL_W-1:0];
	end

	always_comb begin
		ld_c = vld_q[idx] ? CRED_W'(signed'(cred_rd_q)) : '0;
		qsel = (live_q == '0) ? '0 : div_q;
		qs   = (|qsel[DIV_N_W-1:31]) ? cred_t'(34'sh0_8000_0000)
			: cred_t'({3'b000, qsel[30:0]});
		cadd = c_q + qs;
		if (cadd > cred_t'({4'b0, ceil_q}))
			cadd = cred_t'({4'b0, ceil_q});
		x1 = mv_amt(r_q, -c_q);
		x2 = mv_amt(c_q - cred_t'({4'b0, burst_q}), cred_t'({4'b0, ceil_q}));
		x3 = mv_amt(sur_q, cred_t'({4'b0, gburst_q}) - r_q);
		cchg = c_q - cred_t'({14'b0, cost_q});
		if (cchg < CREDIT_LOW)
			cchg = CREDIT_LOW;
		negc = -c_q;
		if (rate_q == '0)
			w = WAKE_CAP;
		else if (div_q > DIV_N_W'(WAKE_CAP))
			w = WAKE_CAP;
		else
			w = div_q[TMO_W-1:0];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q   <= 20'd1000;
			rate_q   <= 30'd200000;
			burst_q  <= 30'd10000;
			gburst_q <= 30'd100000;
			floor_q  <= 30'd50000;
			ceil_q   <= 30'd1000000000;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WRITE_COST:   cost_q   <= cfg_data[COST_W-1:0];
				CFG_REFILL_RATE:  rate_q   <= cfg_data;
				CFG_CLIENT_BURST: burst_q  <= cfg_data;
				CFG_GLOBAL_BURST: gburst_q <= cfg_data;
				CFG_FLOOR:        floor_q  <= cfg_data;
				CFG_CEILING:      ceil_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories: read on accept, written once as the result leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			cred_rd_q  <= cred_mem[s_idx];
			stamp_rd_q <= stamp_mem[s_idx];
		end
		if (leave_out && in_range) begin
			cred_mem[idx] <= c_q[MEMC_W-1:0];
			if (cmd_q != CMD_CLOSE)
				stamp_mem[idx] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			aff_q <= '0;
		end else if (leave_out && in_range) begin
			vld_q[idx] <= 1'b1;
			if (cmd_q == CMD_OPEN)
				aff_q[idx] <= 1'b0;
			else if (newly_q)
				aff_q[idx] <= 1'b1;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			live_q   <= '0;
			r_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (leave_out)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept)
						st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (!in_range)
						st_q <= ST_OUT;
					else begin
						case (cmd_q)
							CMD_OPEN: begin
								if (live_q < LIVE_CAP)
									live_q <= live_q + LIVE_W'(1);
								st_q <= ST_OPEN;
							end
							CMD_CLOSE: begin
								if (live_q != '0)
									live_q <= live_q - LIVE_W'(1);
								st_q <= ST_CLOSE;
							end
							default: st_q <= ST_MUL;
						endcase
					end
				end
				ST_OPEN: begin
					// fund new client from reserve, down to -floor
					if (mv_amt(r_q + cred_t'({4'b0, floor_q}),
						cred_t'({4'b0, burst_q})) > 0)
						r_q <= r_q - mv_amt(r_q + cred_t'({4'b0, floor_q}),
							cred_t'({4'b0, burst_q}));
					st_q <= ST_OUT;
				end
				ST_CLOSE: begin
					r_q  <= r_q + mv_amt(c_q, cred_t'({4'b0, burst_q}) - r_q);
					st_q <= ST_OUT;
				end
				ST_MUL:  st_q <= (live_q == '0) ? ST_ADD : ST_DSET;
				ST_DSET: st_q <= ST_DIV;
				ST_DIV: begin
					if (div_done)
						st_q <= tq_q ? ST_TFIN : ST_ADD;
				end
				ST_ADD: st_q <= ST_MV1;
				ST_MV1: begin
					r_q  <= r_q - x1;
					st_q <= ST_MV2;
				end
				ST_MV2: st_q <= ST_MV3;
				ST_MV3: begin
					r_q  <= r_q + x3;
					st_q <= (cmd_q == CMD_CHARGE) ? ST_CHG : ST_TQ;
				end
				ST_CHG: st_q <= ST_OUT;
				ST_TQ:  st_q <= (c_q < 0 && prev_q != '0) ? ST_TM2 : ST_OUT;
				ST_TM2: st_q <= (rate_q == '0) ? ST_TFIN : ST_DSET;
				ST_TFIN: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q   <= s_tuser;
					cli_q   <= s_tdata[CLIENT_W-1:0];
					now_q   <= s_tdata[CLIENT_W+NOW_W-1:CLIENT_W];
					prev_q  <= s_tdata[CLIENT_W+NOW_W+TMO_W-1:CLIENT_W+NOW_W];
					tmo_q   <= s_tdata[CLIENT_W+NOW_W+TMO_W-1:CLIENT_W+NOW_W];
					newly_q <= 1'b0;
					tq_q    <= 1'b0;
				end
			end
			ST_LOAD: begin
				c_q  <= (!in_range || cmd_q == CMD_OPEN) ? '0 : ld_c;
				el_q <= el_n;
			end
			ST_OPEN: c_q <= mv_amt(r_q + cred_t'({4'b0, floor_q}), cred_t'({4'b0, burst_q}));
			ST_CLOSE: c_q <= c_q - mv_amt(c_q, cred_t'({4'b0, burst_q}) - r_q);
			ST_MUL: begin
				prod_q <= DIV_N_W'(el_q) * DIV_N_W'(rate_q);
				dvs_q  <= DIV_D_W'(live_q) * DIV_D_W'(MS_PER_S);
			end
			ST_ADD: c_q <= cadd;
			ST_MV1: c_q <= c_q + x1;
			ST_MV2: begin
				c_q   <= c_q - x2;
				sur_q <= x2;
			end
			ST_CHG: begin
				c_q     <= cchg;
				newly_q <= (cchg < 0) && !aff_q[idx];
			end
			ST_TQ: begin
				prod_q <= DIV_N_W'(negc[30:0]) * DIV_N_W'(live_q);
				tq_q   <= 1'b1;
			end
			ST_TM2: begin
				prod_q <= DIV_N_W'(prod_q[37:0]) * DIV_N_W'(MS_PER_S);
				dvs_q  <= rate_q;
			end
			ST_TFIN: begin
				if (prev_q == -32'sd1 || $signed({1'b0, w}) < 33'(prev_q))
					tmo_q <= w;
			end
			ST_OUT: begin
				if (out_free)
					m_tdata <= {newly_q, tmo_q, c_q[CRED_W-1], r_q[OCRED_W-1:0],
						c_q[OCRED_W-1:0]};
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/scwrl_chk.sv
// Port-level checker for the rate limiter, bound to the top level.
module scwrl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new transaction taken while busy");

	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62] == m_tdata[30])
		else $error("blocked does not match credit sign");

	a_newly: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[95] |-> m_tdata[62])
		else $error("newly affected client not blocked");
endmodule

bind shared_credit_write_rate_limiter_unit scwrl_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
